FILE: rtl/assert_macros.svh
// Assertion macros for the segment table allocator.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STA_ASSERT(lbl, clk, rst, prop, msg)
`define STA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/sta_pkg.sv
// Shared types and codes for the segment table allocator.
// No dependencies.
package sta_pkg;

   typedef struct packed {
      logic [31:0] virt_base;
      logic [31:0] phys_base;
      logic [31:0] size;
      logic [15:0] owner;
      logic        occupied;
   } entry_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic [31:0] phys_address;
      logic [31:0] amount;
      logic [15:0] owner;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_address;
   } rsp_type;

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_FIT     = 3'd1;
   localparam logic [2:0] KIND_FIXED   = 3'd2;
   localparam logic [2:0] KIND_FREE    = 3'd3;
   localparam logic [2:0] KIND_COMPACT = 3'd4;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

FILE: rtl/sta_cell.sv
// One table slot of the rotating segment ring.
// Depends on sta_pkg.
module sta_cell (
   input  logic               clock,
   input  logic               shift,
   input  sta_pkg::entry_type entry_in,
   output sta_pkg::entry_type entry_out
);

   sta_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

FILE: rtl/sta_ctrl.sv
// Request sequencer: drives ring rotations, decides each slot as it passes the head.
// Depends on sta_pkg.
module sta_ctrl #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PAGE_BYTES    = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sta_pkg::req_type   req_data,
   output logic               rsp_valid,
   output sta_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data,
   input  sta_pkg::entry_type head,
   input  sta_pkg::entry_type next,
   output logic               shift,
   output sta_pkg::entry_type tail
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] N_C    = CW'(TABLE_ENTRIES);
   localparam logic [IW-1:0] K_LAST = IW'(TABLE_ENTRIES - 1);
   localparam logic [32:0]   PG_LOW = 33'(PAGE_BYTES - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SORT  = 3'd3;
   localparam logic [2:0] S_MERGE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]         state_ff, state_in;
   sta_pkg::req_type   req_ff, req_in;
   logic [IW-1:0]      k_ff, k_in;
   logic [CW-1:0]      pass_ff, pass_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               found_ff, found_in;
   logic               merged_ff, merged_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        res_ff, res_in;
   logic [1:0]         napp_ff, napp_in;
   sta_pkg::entry_type app0_ff, app0_in;
   sta_pkg::entry_type app1_ff, app1_in;
   sta_pkg::entry_type carry_ff, carry_in;
   logic [15:0]        kern_ff, kern_in;
   logic [31:0]        page_ff, page_in;
   logic [32:0]        alloc_ff, alloc_in;
   logic [32:0]        pend_ff, pend_in;

   logic [CW-1:0]      kc;
   logic               in_tbl, at_app0, at_app1;
   logic [32:0]        seg_end;
   logic               fix_fit, need_over;
   logic [31:0]        left_sz, right_sz, pbase;
   logic [1:0]         need;
   sta_pkg::entry_type left_e, right_e;

   assign kc      = CW'(k_ff);
   assign in_tbl  = kc < count_ff;
   assign at_app0 = (napp_ff != 2'd0) && (kc == count_ff);
   assign at_app1 = (napp_ff == 2'd2) && ((CW+1)'(k_ff) == (CW+1)'(count_ff) + 1'b1);

   assign page_in  = req_data.address & ~PG_LOW[31:0];
   assign alloc_in = ({1'b0, req_data.amount} + PG_LOW) & ~PG_LOW;

   // fixed-address window test on the head slot
   assign seg_end   = {1'b0, head.virt_base} + {1'b0, head.size};
   assign fix_fit   = !head.occupied && !alloc_ff[32] && (head.virt_base <= page_ff)
                      && (pend_ff <= seg_end);
   assign left_sz   = page_ff - head.virt_base;
   assign right_sz  = 32'(seg_end - pend_ff);
   assign need      = 2'(left_sz != 32'd0) + 2'(right_sz != 32'd0);
   assign need_over = ((CW+1)'(count_ff) + (CW+1)'(need)) > (CW+1)'(N_C);
   assign pbase     = head.phys_base + left_sz;

   always_comb begin
      left_e.virt_base  = head.virt_base;
      left_e.phys_base  = head.phys_base;
      left_e.size       = left_sz;
      left_e.owner      = head.owner;
      left_e.occupied   = 1'b0;
      right_e.virt_base = pend_ff[31:0];
      right_e.phys_base = pbase + alloc_ff[31:0];
      right_e.size      = right_sz;
      right_e.owner     = head.owner;
      right_e.occupied  = 1'b0;
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      k_in      = k_ff;
      pass_in   = pass_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      merged_in = merged_ff;
      status_in = status_ff;
      res_in    = res_ff;
      napp_in   = napp_ff;
      app0_in   = app0_ff;
      app1_in   = app1_ff;
      carry_in  = carry_ff;
      kern_in   = kern_ff;
      pend_in   = pend_ff;
      tail      = head;

      if (csr_valid) begin
         kern_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_data;
               k_in      = '0;
               pass_in   = '0;
               found_in  = 1'b0;
               merged_in = 1'b0;
               napp_in   = 2'd0;
               res_in    = 32'd0;
               state_in  = S_PREP;
               case (req_data.kind)
                  sta_pkg::KIND_ADD: begin
                     if (count_ff >= N_C) begin
                        status_in = sta_pkg::ST_FULL;
                     end else begin
                        status_in         = sta_pkg::ST_DONE;
                        napp_in           = 2'd1;
                        app0_in.virt_base = req_data.address;
                        app0_in.phys_base = req_data.phys_address;
                        app0_in.size      = req_data.amount;
                        app0_in.owner     = 16'd0;
                        app0_in.occupied  = 1'b0;
                        res_in            = req_data.address;
                     end
                  end
                  sta_pkg::KIND_FIT,
                  sta_pkg::KIND_FIXED: status_in = sta_pkg::ST_NOFIT;
                  sta_pkg::KIND_FREE:  status_in = sta_pkg::ST_NOTFOUND;
                  default:             status_in = sta_pkg::ST_DONE;
               endcase
            end
         end

         S_PREP: begin
            pend_in  = {1'b0, page_ff} + alloc_ff;
            state_in = (req_ff.kind == sta_pkg::KIND_COMPACT) ? S_SORT : S_SCAN;
         end

         S_SCAN: begin
            if (at_app0) begin
               tail = app0_ff;
            end else if (at_app1) begin
               tail = app1_ff;
            end else if (in_tbl && !found_ff) begin
               case (req_ff.kind)
                  sta_pkg::KIND_FIT: begin
                     if (!head.occupied && head.size >= req_ff.amount) begin
                        found_in = 1'b1;
                        if (head.size == req_ff.amount) begin
                           tail.occupied = 1'b1;
                           tail.owner    = req_ff.owner;
                           status_in     = sta_pkg::ST_DONE;
                           res_in        = head.virt_base;
                        end else if (count_ff >= N_C) begin
                           status_in = sta_pkg::ST_FULL;
                        end else begin
                           app0_in.virt_base = head.virt_base;
                           app0_in.phys_base = head.phys_base;
                           app0_in.size      = req_ff.amount;
                           app0_in.owner     = req_ff.owner;
                           app0_in.occupied  = 1'b1;
                           napp_in           = 2'd1;
                           tail.virt_base    = head.virt_base + req_ff.amount;
                           tail.phys_base    = head.phys_base + req_ff.amount;
                           tail.size         = head.size - req_ff.amount;
                           status_in         = sta_pkg::ST_DONE;
                           res_in            = head.virt_base;
                        end
                     end
                  end
                  sta_pkg::KIND_FIXED: begin
                     if (fix_fit) begin
                        found_in = 1'b1;
                        if (need_over) begin
                           status_in = sta_pkg::ST_FULL;
                        end else begin
                           if (left_sz != 32'd0) begin
                              app0_in = left_e;
                              app1_in = right_e;
                           end else begin
                              app0_in = right_e;
                           end
                           napp_in        = need;
                           tail.virt_base = page_ff;
                           tail.phys_base = pbase;
                           tail.size      = alloc_ff[31:0];
                           tail.owner     = req_ff.owner;
                           tail.occupied  = 1'b1;
                           status_in      = sta_pkg::ST_DONE;
                           res_in         = page_ff;
                        end
                     end
                  end
                  sta_pkg::KIND_FREE: begin
                     if ((head.owner == req_ff.owner || req_ff.owner == kern_ff)
                         && head.virt_base == req_ff.address) begin
                        found_in      = 1'b1;
                        tail.occupied = 1'b0;
                        tail.owner    = 16'd0;
                        status_in     = sta_pkg::ST_DONE;
                        res_in        = req_ff.address;
                     end
                  end
                  default: ;
               endcase
            end
            if (k_ff == K_LAST) begin
               k_in     = '0;
               count_in = count_ff + CW'(napp_ff);
               state_in = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // exchange sort: carry holds slot pass_ff, written back next rotation
         S_SORT: begin
            if (pass_ff != '0 && kc == pass_ff - 1'b1) begin
               tail = carry_ff;
            end else if (pass_ff < count_ff && kc == pass_ff) begin
               carry_in = head;
            end else if (pass_ff < count_ff && kc > pass_ff && in_tbl
                         && carry_ff.virt_base > head.virt_base) begin
               tail     = carry_ff;
               carry_in = head;
            end
            if (k_ff == K_LAST) begin
               k_in = '0;
               if (pass_ff == count_ff) begin
                  state_in = S_MERGE;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // one merge per rotation; later slots close up by one
         S_MERGE: begin
            if (merged_ff) begin
               tail = next;
            end else if (((CW+1)'(k_ff) + 1'b1) < (CW+1)'(count_ff)
                         && !head.occupied && !next.occupied) begin
               tail.size = head.size + next.size;
               merged_in = 1'b1;
            end
            if (k_ff == K_LAST) begin
               k_in = '0;
               if (merged_ff) begin
                  count_in  = count_ff - 1'b1;
                  merged_in = 1'b0;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         kern_ff   <= 16'd1;
         k_ff      <= '0;
         pass_ff   <= '0;
         found_ff  <= 1'b0;
         merged_ff <= 1'b0;
         napp_ff   <= 2'd0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         kern_ff   <= kern_in;
         k_ff      <= k_in;
         pass_ff   <= pass_in;
         found_ff  <= found_in;
         merged_ff <= merged_in;
         napp_ff   <= napp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      res_ff    <= res_in;
      app0_ff   <= app0_in;
      app1_ff   <= app1_in;
      carry_ff  <= carry_in;
      pend_ff   <= pend_in;
      if (state_ff == S_IDLE) begin
         page_ff  <= page_in;
         alloc_ff <= alloc_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign shift     = (state_ff == S_SCAN) || (state_ff == S_SORT) || (state_ff == S_MERGE);
   assign rsp_valid = (state_ff == S_DONE);
   assign csr_ready = 1'b1;
   assign rsp_data.status         = status_ff;
   assign rsp_data.result_address = (status_ff == sta_pkg::ST_DONE) ? res_ff : 32'd0;

endmodule

FILE: rtl/segment_table_allocator.sv
// Segment table allocator top level: ring of table slots plus the request sequencer.
// Depends on sta_pkg, sta_cell, sta_ctrl and assert_macros.svh.
//
// A request is taken when start is high and busy is low; busy stays high until
// the result has been shown. The result appears on rsp_data for exactly one
// cycle with rsp_valid high, and the receiver cannot hold it off.
// The table lives in a ring of TABLE_ENTRIES cells that rotates one slot per
// cycle past the sequencer while a request is scanning, sorting or merging.
// Add, allocate and free take a prepare step, one pass of the ring and a done
// step; the next request can be taken in the cycle after the result.
// Compact: (entries + 1) sort rotations plus (merges + 1) merge rotations,
// between the same prepare and done steps.
// One request is in flight at a time.
// kernel_owner is written through csr_valid/csr_data (always ready); the user
// must write it only while idle: the block does not enforce this. Reset empties
// the table and sets kernel_owner to 1; the block is ready in the next cycle.
`include "assert_macros.svh"
module segment_table_allocator #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PAGE_BYTES    = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sta_pkg::req_type req_data,
   output logic             rsp_valid,
   output sta_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   sta_pkg::entry_type ring [TABLE_ENTRIES];
   sta_pkg::entry_type tail;
   logic               shift;

   sta_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PAGE_BYTES    (PAGE_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .head      (ring[0]),
      .next      (ring[1]),
      .shift     (shift),
      .tail      (tail)
   );

   for (genvar c = 0; c < TABLE_ENTRIES; c++) begin : g_cell
      if (c == TABLE_ENTRIES - 1) begin : g_last
         sta_cell u_cell (
            .clock     (clock),
            .shift     (shift),
            .entry_in  (tail),
            .entry_out (ring[c])
         );
      end else begin : g_mid
         sta_cell u_cell (
            .clock     (clock),
            .shift     (shift),
            .entry_in  (ring[c+1]),
            .entry_out (ring[c])
         );
      end
   end

   `STA_ASSERT(a_rsp_while_busy, clock, reset, rsp_valid |-> busy, "response outside busy")
   `STA_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept without busy")
   `STA_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "response repeated")
   `STA_ASSERT(a_shift_no_rsp, clock, reset, shift |-> (busy && !rsp_valid), "ring moved badly")

endmodule
